// ===== rtl/core/isw_pkg.sv =====
// Package for the square-wave inductance identification block.
// Holds the controller state type, command/status structs and fixed constants.
package isw_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_DIV_AVG,
    ST_PREP_L,
    ST_DIV_L,
    ST_START_RES,
    ST_DIV_RES,
    ST_OUT
  } state_t;

  // Datapath operations requested by the controller.
  typedef struct packed {
    logic tick;       // apply the sample, update accumulators
    logic start_avg;  // start the current average division
    logic start_l;    // start the inductance division
    logic start_res;  // start the final average division
    logic finish_l;   // fold the quotient into the accepted sum
    logic finish_res; // store the result and clear the run
    logic load_out;   // register the result item
  } isw_cmd_t;

  typedef struct packed {
    logic half_end;
    logic run_end;
    logic di_ok;
    logic div_busy;
    logic running;
  } isw_sts_t;

  localparam int DivW = 48;
  localparam logic [15:0] DiMin = 16'd40;
  localparam logic [16:0] LMin = 17'd168;
  localparam logic [16:0] LMax = 17'd83886;

  localparam logic [2:0] RegInject = 3'd0;
  localparam logic [2:0] RegRes = 3'd1;
  localparam logic [2:0] RegTicks = 3'd2;
  localparam logic [2:0] RegTime = 3'd3;
  localparam logic [2:0] RegAxis = 3'd4;

endpackage

// ===== rtl/core/isw_div.sv =====
// Shared iterative signed divider, one quotient bit per cycle, truncating.
// Depends on isw_pkg for the operand width.
module isw_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [isw_pkg::DivW-1:0] num,
  input  logic signed [isw_pkg::DivW-1:0] den,
  output logic                      busy,
  output logic signed [isw_pkg::DivW-1:0] quo
);
  import isw_pkg::*;

  logic [DivW-1:0] q, r, d;
  logic [5:0]      cnt;
  logic            neg;
  logic [DivW:0]   trial;
  logic [DivW-1:0] rsh;

  assign rsh   = {r[DivW-2:0], q[DivW-1]};
  assign trial = {1'b0, rsh} - {1'b0, d};
  assign quo   = neg ? -q : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(DivW);
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num[DivW-1] ? -num : num;
      d   <= den[DivW-1] ? -den : den;
      r   <= '0;
      neg <= num[DivW-1] ^ den[DivW-1];
    end else if (busy) begin
      if (!trial[DivW]) begin
        r <= trial[DivW-1:0];
        q <= {q[DivW-2:0], 1'b1};
      end else begin
        r <= rsh;
        q <= {q[DivW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/isw_datapath.sv =====
// Datapath: configuration registers, run state, accumulators and the shared divider.
// Depends on isw_pkg and isw_div.
module isw_datapath #(
  parameter int TOTAL_HALVES   = 60,
  parameter int DISCARD_HALVES = 6,
  parameter int MAX_HALF_TICKS = 1023
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_cmd,
  input  logic signed [15:0] in_id,
  input  logic signed [15:0] in_iq,
  input  isw_pkg::isw_cmd_t  cmd,
  output isw_pkg::isw_sts_t  sts,
  output logic [71:0]        out_data
);
  import isw_pkg::*;

  localparam int TW = $clog2(MAX_HALF_TICKS + 1);

  logic [14:0] inject_voltage;
  logic [15:0] phase_resistance;
  logic [9:0]  half_period_ticks;
  logic [23:0] half_period_time;
  logic        axis_select;

  logic        running;
  logic [5:0]  half_count;
  logic [TW-1:0] tick_in_half;
  logic signed [15:0] start_current;
  logic signed [27:0] current_sum;
  logic [22:0] accepted_sum;
  logic [5:0]  accepted_count;
  logic [16:0] ld_store, lq_store;
  logic signed [16:0] ucmd_r;
  logic signed [16:0] di_r;
  logic signed [22:0] ueff_r;
  logic        out_zero;

  logic        div_start, div_busy;
  logic signed [DivW-1:0] div_num, div_den, div_quo;
  logic signed [15:0] i_now;
  logic signed [16:0] ucmd;
  logic [TW-1:0] limit, tick_next;
  logic signed [27:0] sum_next;
  logic [16:0] di_mag;
  logic signed [33:0] drop_prod;
  logic signed [21:0] drop;
  logic signed [22:0] ueff;
  logic signed [DivW-1:0] lnum;
  logic [16:0] res;

  always_ff @(posedge clk) begin
    if (rst) begin
      inject_voltage    <= 15'd4096;
      phase_resistance  <= '0;
      half_period_ticks <= 10'd25;
      half_period_time  <= 24'd20972;
      axis_select       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegInject: inject_voltage    <= cfg_data[14:0];
        RegRes:    phase_resistance  <= cfg_data[15:0];
        RegTicks:  half_period_ticks <= cfg_data[9:0];
        RegTime:   half_period_time  <= cfg_data;
        RegAxis:   axis_select       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign i_now = axis_select ? in_id : in_iq;
  assign ucmd  = half_count[0] ? -$signed({2'b0, inject_voltage})
                               : $signed({2'b0, inject_voltage});
  always_comb begin
    if (32'(half_period_ticks) > MAX_HALF_TICKS) limit = TW'(MAX_HALF_TICKS);
    else limit = TW'(half_period_ticks);
  end
  assign tick_next = tick_in_half + TW'(1);
  assign sum_next  = (tick_in_half == '0) ? 28'(i_now) : current_sum + 28'(i_now);

  // Average quotient is narrow; floor(R*avg/4096) via arithmetic shift.
  assign drop_prod = $signed({1'b0, phase_resistance}) * $signed(div_quo[16:0]);
  assign drop      = 22'(drop_prod >>> 12);
  assign ueff      = 23'(ucmd_r) - 23'(drop);
  assign lnum      = DivW'(ueff_r) * DivW'($signed({1'b0, half_period_time}));
  assign di_mag    = di_r[16] ? 17'(-di_r) : 17'(di_r);

  // The corrected voltage is registered so the two multiplies sit in separate cycles.
  always_ff @(posedge clk) begin
    ueff_r <= ueff;
  end

  always_comb begin
    div_start = cmd.start_avg | cmd.start_l | cmd.start_res;
    div_num   = DivW'(current_sum);
    div_den   = DivW'($signed({1'b0, tick_in_half}));
    if (cmd.start_l) begin
      div_num = lnum;
      div_den = DivW'(di_r);
    end else if (cmd.start_res) begin
      div_num = DivW'($signed({1'b0, accepted_sum}));
      div_den = DivW'($signed({1'b0, accepted_count}));
    end
  end

  isw_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_quo)
  );

  assign res = (accepted_count == '0) ? 17'd0 : div_quo[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      half_count     <= '0;
      tick_in_half   <= '0;
      start_current  <= '0;
      current_sum    <= '0;
      accepted_sum   <= '0;
      accepted_count <= '0;
      ld_store       <= '0;
      lq_store       <= '0;
      out_zero       <= 1'b1;
    end else begin
      if (cmd.tick) begin
        logic run_now;
        run_now = running | in_cmd;
        if (in_cmd) begin
          half_count     <= '0;
          accepted_sum   <= '0;
          accepted_count <= '0;
          ld_store       <= '0;
          lq_store       <= '0;
          running        <= 1'b1;
        end
        ucmd_r   <= in_cmd ? $signed({2'b0, inject_voltage}) : ucmd;
        out_zero <= ~run_now;
        if (run_now) begin
          if (in_cmd || tick_in_half == '0) start_current <= i_now;
          current_sum  <= in_cmd ? 28'(i_now) : sum_next;
          tick_in_half <= in_cmd ? TW'(1) : tick_next;
          di_r <= 17'(i_now) - 17'((in_cmd || tick_in_half == '0) ? i_now : start_current);
        end
      end
      if (cmd.finish_l) begin
        if (div_quo >= DivW'(LMin) && div_quo <= DivW'(LMax)
            && 32'(half_count) >= DISCARD_HALVES) begin
          accepted_sum   <= accepted_sum + 23'(div_quo[16:0]);
          accepted_count <= accepted_count + 6'd1;
        end
      end
      if (cmd.start_avg) begin
        // Half period ends: restart the tick count. The half counter advances when
        // the result of this tick is loaded.
        tick_in_half <= '0;
      end
      if (cmd.finish_res) begin
        if (axis_select) ld_store <= res;
        else             lq_store <= res;
        running        <= 1'b0;
        half_count     <= '0;
        tick_in_half   <= '0;
        start_current  <= '0;
        current_sum    <= '0;
        accepted_sum   <= '0;
        accepted_count <= '0;
        out_zero       <= 1'b1;
      end else if (cmd.load_out && sts.half_end) begin
        half_count <= half_count + 6'd1;
      end
    end
  end

  // Half-end flag is latched with the tick so it survives the divisions.
  logic half_end_r;
  always_ff @(posedge clk) begin
    if (rst) half_end_r <= 1'b0;
    else if (cmd.tick) half_end_r <= (running | in_cmd) &&
        ((in_cmd ? TW'(1) : tick_next) >= limit);
  end

  assign sts.half_end = half_end_r;
  assign sts.run_end  = half_end_r && (32'(half_count) + 1 >= TOTAL_HALVES);
  assign sts.di_ok    = di_mag > 17'(DiMin);
  assign sts.div_busy = div_busy;
  assign sts.running  = running;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data[15:0]  <= (out_zero || axis_select == 1'b0) ? 16'd0 : 16'(ucmd_r);
      out_data[31:16] <= (out_zero || axis_select == 1'b1) ? 16'd0 : 16'(ucmd_r);
      out_data[32]    <= out_zero;
      out_data[49:33] <= ld_store;
      out_data[66:50] <= lq_store;
      out_data[71:67] <= '0;
    end
  end

endmodule

// ===== rtl/core/isw_ctrl.sv =====
// Controller state machine: sequences tick update, divisions and result hand-off.
// Depends on isw_pkg.
module isw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  isw_pkg::isw_sts_t sts,
  output isw_pkg::isw_cmd_t cmd
);
  import isw_pkg::*;

  state_t state, state_next;
  logic   started;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      started <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      started <= cmd.start_avg | cmd.start_l | cmd.start_res;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  logic div_done;
  assign div_done = !started && !sts.div_busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_TICK;
      ST_TICK:      state_next = sts.half_end ? ST_DIV_AVG : ST_OUT;
      ST_DIV_AVG: begin
        if (div_done) begin
          if (sts.di_ok) state_next = ST_PREP_L;
          else if (sts.run_end) state_next = ST_START_RES;
          else state_next = ST_OUT;
        end
      end
      ST_PREP_L:    state_next = ST_DIV_L;
      ST_DIV_L:     if (div_done) state_next = sts.run_end ? ST_START_RES : ST_OUT;
      ST_START_RES: state_next = ST_DIV_RES;
      ST_DIV_RES:   if (div_done) state_next = ST_OUT;
      ST_OUT:       if (!out_valid || out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == ST_IDLE);
    case (state)
      ST_IDLE:      cmd.tick = in_valid;
      ST_TICK:      cmd.start_avg = sts.half_end;
      ST_PREP_L:    cmd.start_l = 1'b1;
      ST_DIV_L:     cmd.finish_l = div_done;
      ST_START_RES: cmd.start_res = 1'b1;
      ST_DIV_RES:   cmd.finish_res = div_done;
      ST_OUT:       cmd.load_out = !out_valid || out_ready;
      default:      cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_TICK) else $error("tick not started");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_one_div: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start_avg, cmd.start_l, cmd.start_res})) else $error("divider clash");
`endif

endmodule

// ===== rtl/core/inductance_square_wave_identification.sv =====
// Square-wave inductance identification, one transaction per control tick.
// A plain tick goes straight to the output; a half end adds the average division, an accepted
// current swing the inductance division, and the last half the final average division.
// One tick at a time: no new tick is taken while the shared divider runs, and the next
// tick is accepted in the cycle after the result loads into the output register.
// Synchronous reset returns the configuration and run registers to defaults and the block to idle (done).
module inductance_square_wave_identification #(
  parameter int TOTAL_HALVES   = 60,
  parameter int DISCARD_HALVES = 6,
  parameter int MAX_HALF_TICKS = 1023
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // id_sample[15:0], iq_sample[31:16]
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // vd, vq, done_res, ld_value, lq_value, pad
);
  import isw_pkg::*;

  isw_cmd_t cmd;
  isw_sts_t sts;

  isw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .sts(sts), .cmd(cmd)
  );

  isw_datapath #(
    .TOTAL_HALVES(TOTAL_HALVES), .DISCARD_HALVES(DISCARD_HALVES),
    .MAX_HALF_TICKS(MAX_HALF_TICKS)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_cmd(s_tuser), .in_id(s_tdata[15:0]), .in_iq(s_tdata[31:16]),
    .cmd(cmd), .sts(sts), .out_data(m_tdata)
  );

endmodule
